// ===== rtl/gea_pkg.sv =====
package gea_pkg;

    localparam int DEF_ENTITY_SLOTS    = 256;
    localparam int DEF_GENERATION_BITS = 16;

    localparam int HANDLE_W     = 24;
    localparam int HANDLE_IDX_W = 8;
    localparam int HANDLE_GEN_W = 16;
    localparam int POS_W        = 8;
    localparam int LIVE_W       = 9;

    // slots examined per scan cycle
    localparam int CHUNK_W = 8;

    typedef enum logic [1:0] {
        FUNC_CREATE  = 2'd0,
        FUNC_DESTROY = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_ACTIVE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE_FULL = 2'd1,
        ST_NOT_FOUND  = 2'd2
    } t_status;

    typedef struct packed {
        t_func                func;
        logic [HANDLE_W-1:0]  handle_in;
        logic [POS_W-1:0]     position;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [HANDLE_W-1:0]  handle_out;
        logic                 is_alive;
        logic [LIVE_W-1:0]    live_count;
    } t_rsp;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_FREE_STEP,
        DP_RANK_STEP,
        DP_BIT_STEP,
        DP_GROW,
        DP_COMMIT,
        DP_QUERY,
        DP_FAIL
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status fail_status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  idx_in_range;
        logic  idx_alive;
        logic  pos_valid;
        logic  free_hit;
        logic  free_end;
        logic  can_grow;
        logic  rank_hit;
        logic  bit_hit;
    } t_dp_sts;

endpackage

// ===== rtl/gea_stream_if.sv =====
interface gea_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/gea_ram.sv =====
module gea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/gea_datapath.sv =====
module gea_datapath import gea_pkg::*; #(
    parameter int ENTITY_SLOTS    = DEF_ENTITY_SLOTS,
    parameter int GENERATION_BITS = DEF_GENERATION_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req_data,
    output t_dp_sts o_sts,
    output t_rsp    o_rsp_data
);
    localparam int IDX_W  = $clog2(ENTITY_SLOTS);
    localparam int CNT_W  = $clog2(ENTITY_SLOTS + 1);
    localparam int NCHUNK = (ENTITY_SLOTS + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD    = NCHUNK * CHUNK_W;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int BIT_W  = $clog2(CHUNK_W);
    localparam int POP_W  = $clog2(CHUNK_W + 1);
    localparam int PICK_W = CHK_W + BIT_W;
    localparam int MAX_A  = (CNT_W > PICK_W) ? CNT_W : PICK_W;
    localparam int MAX_B  = (MAX_A > POS_W) ? MAX_A : POS_W;
    localparam int CMP_W  = MAX_B + 1;

    function automatic logic [BIT_W-1:0] f_lowest(input logic [CHUNK_W-1:0] v);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int j = CHUNK_W - 1; j >= 0; j--) begin
            if (v[j]) begin
                r = BIT_W'(j);
            end
        end
        return r;
    endfunction

    function automatic logic [POP_W-1:0] f_popcount(input logic [CHUNK_W-1:0] v);
        logic [POP_W-1:0] c;
        c = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            c = c + POP_W'(v[j]);
        end
        return c;
    endfunction

    function automatic logic [HANDLE_W-1:0] f_pack(
        input logic [GENERATION_BITS-1:0] gen,
        input logic [IDX_W-1:0]           idx
    );
        return {HANDLE_GEN_W'(gen), HANDLE_IDX_W'(idx)};
    endfunction

    logic [ENTITY_SLOTS-1:0]    r_alive;
    logic [CNT_W-1:0]           r_hw;
    logic [CNT_W-1:0]           r_total;
    t_func                      r_func;
    logic [HANDLE_IDX_W-1:0]    r_idx8;
    logic [POS_W-1:0]           r_rem;
    logic [CHK_W-1:0]           r_chunk;
    logic [BIT_W-1:0]           r_bit;
    logic [IDX_W-1:0]           r_pick;
    t_status                    r_res_status;
    logic [HANDLE_W-1:0]        r_res_handle;
    logic                       r_res_alive;
    t_rsp                       r_out;

    logic [PAD-1:0]             w_pad;
    logic [CHUNK_W-1:0]         w_chunk;
    logic [CHUNK_W-1:0]         w_free;
    logic [PICK_W-1:0]          w_base;
    logic [BIT_W-1:0]           w_free_bit;
    logic [POP_W-1:0]           w_pop;
    logic [IDX_W-1:0]           w_idx;
    logic                       w_last_chunk;
    logic                       w_ram_we;
    logic [IDX_W-1:0]           w_ram_waddr;
    logic [GENERATION_BITS-1:0] w_ram_wdata;
    logic [GENERATION_BITS-1:0] w_ram_rdata;

    always_comb begin
        w_pad = '0;
        w_pad[ENTITY_SLOTS-1:0] = r_alive;
    end

    assign w_chunk      = w_pad[r_chunk * CHUNK_W +: CHUNK_W];
    assign w_base       = {r_chunk, BIT_W'(0)};
    assign w_free_bit   = f_lowest(w_free);
    assign w_pop        = f_popcount(w_chunk);
    assign w_idx        = IDX_W'(r_idx8);
    assign w_last_chunk = (r_chunk == CHK_W'(NCHUNK - 1));

    always_comb begin
        for (int j = 0; j < CHUNK_W; j++) begin
            w_free[j] = !w_chunk[j]
                && ((CMP_W'(w_base) + CMP_W'(j)) < CMP_W'(r_hw));
        end
    end

    always_comb begin
        o_sts.func         = r_func;
        o_sts.idx_in_range = int'(r_idx8) < ENTITY_SLOTS;
        o_sts.idx_alive    = r_alive[w_idx];
        o_sts.pos_valid    = CMP_W'(r_rem) < CMP_W'(r_total);
        o_sts.free_hit     = |w_free;
        o_sts.free_end     = w_last_chunk
            || ((CMP_W'(w_base) + CMP_W'(CHUNK_W)) >= CMP_W'(r_hw));
        o_sts.can_grow     = r_hw < CNT_W'(ENTITY_SLOTS);
        o_sts.rank_hit     = CMP_W'(r_rem) < CMP_W'(w_pop);
        o_sts.bit_hit      = w_chunk[r_bit] && (r_rem == '0);
    end

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_pick;
        w_ram_wdata = w_ram_rdata + GENERATION_BITS'(1);
        if (i_cmd.op == DP_GROW) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = IDX_W'(r_hw);
            w_ram_wdata = '0;
        end else if (i_cmd.op == DP_COMMIT && r_func == FUNC_DESTROY) begin
            w_ram_we = 1'b1;
        end
    end

    gea_ram #(
        .WIDTH (GENERATION_BITS),
        .DEPTH (ENTITY_SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_pick),
        .o_rdata (w_ram_rdata)
    );

    // alive bitmap and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= '0;
            r_hw    <= '0;
            r_total <= '0;
        end else begin
            case (i_cmd.op)
                DP_GROW: begin
                    r_alive[IDX_W'(r_hw)] <= 1'b1;
                    r_hw                  <= r_hw + CNT_W'(1);
                    r_total               <= r_total + CNT_W'(1);
                end
                DP_COMMIT: begin
                    if (r_func == FUNC_CREATE) begin
                        r_alive[r_pick] <= 1'b1;
                        r_total         <= r_total + CNT_W'(1);
                    end else if (r_func == FUNC_DESTROY) begin
                        r_alive[r_pick] <= 1'b0;
                        r_total         <= r_total - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-beat working registers and result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_func  <= i_req_data.func;
                r_idx8  <= i_req_data.handle_in[HANDLE_IDX_W-1:0];
                r_rem   <= i_req_data.position;
                r_chunk <= '0;
                r_bit   <= '0;
                r_pick  <= IDX_W'(i_req_data.handle_in[HANDLE_IDX_W-1:0]);
            end
            DP_FREE_STEP: begin
                if (|w_free) begin
                    r_pick <= IDX_W'({r_chunk, w_free_bit});
                end else if (!w_last_chunk) begin
                    r_chunk <= r_chunk + CHK_W'(1);
                end
            end
            DP_RANK_STEP: begin
                if (!(CMP_W'(r_rem) < CMP_W'(w_pop))) begin
                    r_rem   <= r_rem - POS_W'(w_pop);
                    r_chunk <= r_chunk + CHK_W'(1);
                end
            end
            DP_BIT_STEP: begin
                if (w_chunk[r_bit]) begin
                    if (r_rem == '0) begin
                        r_pick <= IDX_W'({r_chunk, r_bit});
                    end else begin
                        r_rem <= r_rem - POS_W'(1);
                    end
                end
                r_bit <= r_bit + BIT_W'(1);
            end
            DP_GROW: begin
                r_res_status <= ST_OK;
                r_res_handle <= f_pack('0, IDX_W'(r_hw));
                r_res_alive  <= 1'b1;
            end
            DP_COMMIT: begin
                r_res_status <= ST_OK;
                if (r_func == FUNC_DESTROY) begin
                    r_res_handle <= '0;
                    r_res_alive  <= 1'b0;
                end else begin
                    r_res_handle <= f_pack(w_ram_rdata, r_pick);
                    r_res_alive  <= 1'b1;
                end
            end
            DP_QUERY: begin
                r_res_handle <= '0;
                if (int'(r_idx8) < ENTITY_SLOTS) begin
                    r_res_status <= ST_OK;
                    r_res_alive  <= r_alive[w_idx];
                end else begin
                    r_res_status <= ST_RANGE_FULL;
                    r_res_alive  <= 1'b0;
                end
            end
            DP_FAIL: begin
                r_res_status <= i_cmd.fail_status;
                r_res_handle <= '0;
                r_res_alive  <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out.status     <= r_res_status;
            r_out.handle_out <= r_res_handle;
            r_out.is_alive   <= r_res_alive;
            r_out.live_count <= LIVE_W'(r_total);
        end
    end

    assign o_rsp_data = r_out;

    a_total_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_alive) == int'(r_total))
        else $error("live total differs from alive bitmap");

    a_total_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_hw && int'(r_hw) <= ENTITY_SLOTS)
        else $error("counter bounds broken");

    a_destroy_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_COMMIT && r_func == FUNC_DESTROY) |=> !r_alive[$past(r_pick)])
        else $error("destroyed slot still alive");
endmodule

// ===== rtl/gea_ctrl.sv =====
module gea_ctrl import gea_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FREE,
        S_GROW,
        S_RANK,
        S_BIT,
        S_GEN_RD,
        S_COMMIT,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state           = r_state;
        o_cmd.op          = DP_NOP;
        o_cmd.fail_status = ST_OK;
        o_cmd.out_load    = 1'b0;
        o_in_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.func)
                    FUNC_CREATE: begin
                        n_state = S_FREE;
                    end
                    FUNC_DESTROY: begin
                        if (!i_sts.idx_in_range) begin
                            o_cmd.op          = DP_FAIL;
                            o_cmd.fail_status = ST_RANGE_FULL;
                            n_state           = S_RESULT;
                        end else if (!i_sts.idx_alive) begin
                            o_cmd.op          = DP_FAIL;
                            o_cmd.fail_status = ST_NOT_FOUND;
                            n_state           = S_RESULT;
                        end else begin
                            n_state = S_GEN_RD;
                        end
                    end
                    FUNC_QUERY: begin
                        o_cmd.op = DP_QUERY;
                        n_state  = S_RESULT;
                    end
                    FUNC_ACTIVE: begin
                        if (!i_sts.pos_valid) begin
                            o_cmd.op          = DP_FAIL;
                            o_cmd.fail_status = ST_NOT_FOUND;
                            n_state           = S_RESULT;
                        end else begin
                            n_state = S_RANK;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FREE: begin
                o_cmd.op = DP_FREE_STEP;
                if (i_sts.free_hit) begin
                    n_state = S_GEN_RD;
                end else if (i_sts.free_end) begin
                    n_state = S_GROW;
                end
            end
            S_GROW: begin
                if (i_sts.can_grow) begin
                    o_cmd.op = DP_GROW;
                end else begin
                    o_cmd.op          = DP_FAIL;
                    o_cmd.fail_status = ST_RANGE_FULL;
                end
                n_state = S_RESULT;
            end
            S_RANK: begin
                o_cmd.op = DP_RANK_STEP;
                if (i_sts.rank_hit) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                o_cmd.op = DP_BIT_STEP;
                if (i_sts.bit_hit) begin
                    n_state = S_GEN_RD;
                end
            end
            S_GEN_RD: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.op = DP_COMMIT;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_out_valid && !i_out_ready) |=> (r_state == S_RESULT))
        else $error("result overwrote an unclaimed beat");

    a_valid_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESULT))
        else $error("output valid raised outside result state");

    a_read_then_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEN_RD) |=> (r_state == S_COMMIT))
        else $error("generation read not followed by commit");
endmodule

// ===== rtl/generational_entity_allocator.sv =====
// Channel  Dir  Payload                                  Beat taken when
// i_req    in   func, handle_in, position                i_req.valid & i_req.ready
// o_rsp    out  status, handle_out, is_alive, live_count o_rsp.valid & o_rsp.ready
//
// One request at a time; the alive bitmap is scanned 8 slots per cycle, and active-at
// then walks the hit group slot by slot. A create takes the lowest free slot below the
// high-water mark, else grows it; destroy, reuse of a freed slot and active-at read the
// generation RAM before commit. Failed checks go straight to the result state.
// Synchronous active-low reset clears alive marks and counters; the generation RAM
// needs no clearing, since slots at or above the high-water mark are written before use.
// One output register holds a result, so a new request is taken while it waits; the
// block only stalls in the result state when the next result is done before that.
module generational_entity_allocator import gea_pkg::*; #(
    parameter int ENTITY_SLOTS    = DEF_ENTITY_SLOTS,
    parameter int GENERATION_BITS = DEF_GENERATION_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gea_stream_if.sink    i_req,
    gea_stream_if.source  o_rsp
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;
    t_rsp    w_rsp_data;

    gea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gea_datapath #(
        .ENTITY_SLOTS    (ENTITY_SLOTS),
        .GENERATION_BITS (GENERATION_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_data (i_req.payload),
        .o_sts      (w_sts),
        .o_rsp_data (w_rsp_data)
    );

    assign i_req.ready   = w_in_ready;
    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_rsp_data;
endmodule
